>>> rtl/cfmdl_pkg.sv
// shared widths, types and defaults of the crossfading delay line
`timescale 1ns / 1ps

package cfmdl_pkg;

  localparam int SAMPLE_W = 24;
  localparam int DELAY_W  = 10;

  localparam int LINE_DEPTH_DEF     = 1024;
  localparam int CHANNELS_DEF       = 2;
  localparam int TRANSITION_LEN_DEF = 256;

  localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 10'd1022;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [DELAY_W-1:0]         delay_t;

endpackage

>>> rtl/cfmdl_in_if.sv
// input channel: one sample beat with channel, frame end and delay request
`timescale 1ns / 1ps

interface cfmdl_in_if
  import cfmdl_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    channel;
  logic    frame_end;
  delay_t  delay_request;

  modport source (output valid, output sample_in, output channel, output frame_end,
                  output delay_request, input ready);
  modport sink   (input valid, input sample_in, input channel, input frame_end,
                  input delay_request, output ready);
endinterface

>>> rtl/cfmdl_out_if.sv
// result channel: one delayed, crossfaded sample beat
`timescale 1ns / 1ps

interface cfmdl_out_if
  import cfmdl_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    out_channel;
  logic    out_frame_end;

  modport source (output valid, output sample_out, output out_channel,
                  output out_frame_end, input ready);
  modport sink   (input valid, input sample_out, input out_channel,
                  input out_frame_end, output ready);
endinterface

>>> rtl/cfmdl_ram.sv
// generic simple dual-port ram, one write and one registered read port
`timescale 1ns / 1ps

module cfmdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/crossfading_multichannel_delay_line.sv
// top level of the crossfading multichannel delay line
`timescale 1ns / 1ps

// Each accepted beat writes its sample into its channel's circular line and returns one
// sample read at the old and new delay taps, mixed linearly over TRANSITION_LEN frames.
// A new beat is taken once the previous beat has read both taps and can move on; the line
// memory has one read port and each beat reads two taps from it. Results pass a read stage,
// a multiply stage and a result register; the last two let up to two more beats enter while
// a result waits. After reset and after every cfg write a pass zeroes all the
// min(CHANNELS,2)*LINE_DEPTH line words (2048 by default) while in_beat.ready is low.
// The delay request is taken on channel-0 beats; delay and fade advance on frame end.

module crossfading_multichannel_delay_line
  import cfmdl_pkg::*;
#(
  parameter int LINE_DEPTH     = LINE_DEPTH_DEF,
  parameter int CHANNELS       = CHANNELS_DEF,
  parameter int TRANSITION_LEN = TRANSITION_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  cfmdl_in_if.sink           in_beat,
  cfmdl_out_if.source        out_beat,
  input  logic               cfg_we,
  input  logic [DELAY_W-1:0] cfg_wdata
);

  localparam int MEM_CH    = (CHANNELS > 2) ? 2 : CHANNELS;
  localparam int MEM_DEPTH = MEM_CH * LINE_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int PW        = $clog2(LINE_DEPTH);
  localparam int TW        = (PW + 1 > DELAY_W + 1) ? PW + 1 : DELAY_W + 1;
  localparam int RW        = $clog2(TRANSITION_LEN + 1);
  localparam int SH        = $clog2(TRANSITION_LEN);
  localparam int PRW       = SAMPLE_W + 2 + RW;

  // configuration and fade state
  delay_t        max_delay_r;
  logic [PW-1:0] wp_r, wp_nxt;
  logic          started_r, started_nxt;
  delay_t        settled_r, settled_nxt;
  delay_t        from_r, from_nxt;
  delay_t        to_r, to_nxt;
  logic [RW-1:0] rem_r, rem_nxt;

  // clearing pass
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  // read stage
  logic          r_valid_r;
  logic          r_phase_r;
  sample_t       r_s_r;
  logic          r_ch_r;
  logic          r_fe_r;
  logic          r_fwd_from_r;
  logic          r_fwd_to_r;
  logic [AW-1:0] r_to_addr_r;
  logic [RW-1:0] r_w_r;
  sample_t       r_prev_r;

  // multiply stage
  logic                  m_valid_r;
  logic signed [PRW-1:0] m_prod_r;
  sample_t               m_prev_r;
  logic                  m_ch_r;
  logic                  m_fe_r;

  // output register
  logic    out_valid_r;
  sample_t out_sample_r;
  logic    out_ch_r;
  logic    out_fe_r;

  // combinational
  logic          ch_ok;
  logic [TW-1:0] cap;
  logic [TW-1:0] md_lim;
  logic [TW-1:0] req_ext;
  delay_t        d_clamped;
  delay_t        from_cur, to_cur, settled_cur;
  logic          started_cur;
  logic [RW-1:0] rem_cur, rem_dec;
  logic [TW-1:0] wp_ext, from_ext, to_ext, wp_inc;
  logic [PW-1:0] tap_from, tap_to;
  logic [AW-1:0] base_addr;
  logic [AW-1:0] wp_addr, from_addr, to_addr;
  logic [RW-1:0] weight;

  logic          o_free, m_free, r_leave, accept;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  sample_t       ram_wdata, ram_rdata;
  sample_t       tgt;
  logic [SAMPLE_W:0]     diff;
  logic signed [PRW-1:0] prod;
  logic signed [PRW-1:0] prod_sh;
  logic [SAMPLE_W+1:0]   mix_sum;

  assign ch_ok = (CHANNELS > 1) || (in_beat.channel == 1'b0);

  always_comb begin
    // capacity = min(max_delay, LINE_DEPTH-2) + 2
    md_lim = (TW'(max_delay_r) > TW'(LINE_DEPTH - 2)) ? TW'(LINE_DEPTH - 2)
                                                       : TW'(max_delay_r);
    cap     = md_lim + TW'(2);
    req_ext = TW'(in_beat.delay_request);
    d_clamped = (req_ext > cap - TW'(1)) ? DELAY_W'(cap - TW'(1)) : in_beat.delay_request;

    started_cur = started_r;
    settled_cur = settled_r;
    from_cur    = from_r;
    to_cur      = to_r;
    rem_cur     = rem_r;
    if (in_beat.channel == 1'b0) begin
      if (!started_r) begin
        started_cur = 1'b1;
        settled_cur = d_clamped;
        from_cur    = d_clamped;
        to_cur      = d_clamped;
      end else if (d_clamped != to_r) begin
        from_cur = settled_r;
        to_cur   = d_clamped;
        rem_cur  = RW'(TRANSITION_LEN);
      end
    end

    started_nxt = started_cur;
    settled_nxt = settled_cur;
    from_nxt    = from_cur;
    to_nxt      = to_cur;
    rem_nxt     = rem_cur;
    rem_dec     = rem_cur - RW'(1);
    wp_ext      = TW'(wp_r);
    wp_inc      = wp_ext + TW'(1);
    wp_nxt      = wp_r;
    if (in_beat.frame_end) begin
      if (rem_cur != '0) begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          settled_nxt = to_cur;
          from_nxt    = to_cur;
        end
      end
      wp_nxt = (wp_inc == cap) ? '0 : PW'(wp_inc);
    end

    // delays stay below capacity, so one wrap at most
    from_ext = TW'(from_cur);
    to_ext   = TW'(to_cur);
    tap_from = (wp_ext >= from_ext) ? PW'(wp_ext - from_ext) : PW'(wp_ext + cap - from_ext);
    tap_to   = (wp_ext >= to_ext) ? PW'(wp_ext - to_ext) : PW'(wp_ext + cap - to_ext);

    base_addr = (MEM_CH > 1 && in_beat.channel) ? AW'(LINE_DEPTH % MEM_DEPTH) : '0;
    wp_addr   = base_addr + AW'(wp_r);
    from_addr = base_addr + AW'(tap_from);
    to_addr   = base_addr + AW'(tap_to);
    weight    = RW'(TRANSITION_LEN) - rem_cur;
  end

  // pipeline handshake
  assign o_free  = !out_valid_r || out_beat.ready;
  assign m_free  = !m_valid_r || o_free;
  assign r_leave = r_valid_r && r_phase_r && m_free;
  assign in_beat.ready = !clr_active_r && (!r_valid_r || r_leave);
  assign accept  = in_beat.valid && in_beat.ready;

  // memory port use: write with first tap read on accept, second tap read in the cycle after
  always_comb begin
    ram_we    = clr_active_r || (accept && ch_ok);
    ram_waddr = clr_active_r ? clr_addr_r : wp_addr;
    ram_wdata = clr_active_r ? '0 : in_beat.sample_in;
    ram_re    = accept || (r_valid_r && !r_phase_r);
    ram_raddr = accept ? from_addr : r_to_addr_r;
  end

  cfmdl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MEM_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_delay_r  <= MAX_DELAY_RST;
      wp_r         <= '0;
      started_r    <= 1'b0;
      settled_r    <= '0;
      from_r       <= '0;
      to_r         <= '0;
      rem_r        <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (cfg_we) begin
      max_delay_r  <= cfg_wdata;
      wp_r         <= '0;
      started_r    <= 1'b0;
      settled_r    <= '0;
      from_r       <= '0;
      to_r         <= '0;
      rem_r        <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MEM_DEPTH - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (accept) begin
        wp_r      <= wp_nxt;
        started_r <= started_nxt;
        settled_r <= settled_nxt;
        from_r    <= from_nxt;
        to_r      <= to_nxt;
        rem_r     <= rem_nxt;
      end
    end
  end

  // control of read, multiply and output stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r   <= 1'b0;
      r_phase_r   <= 1'b0;
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        r_valid_r <= 1'b1;
        r_phase_r <= 1'b0;
      end else if (r_leave) begin
        r_valid_r <= 1'b0;
      end else if (r_valid_r) begin
        r_phase_r <= 1'b1;
      end

      if (r_leave) begin
        m_valid_r <= 1'b1;
      end else if (o_free) begin
        m_valid_r <= 1'b0;
      end

      if (m_valid_r && o_free) begin
        out_valid_r <= 1'b1;
      end else if (out_beat.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // delay zero and unstored channels take the incoming sample directly
  assign tgt  = r_fwd_to_r ? r_s_r : ram_rdata;
  assign diff = {tgt[SAMPLE_W-1], tgt} - {r_prev_r[SAMPLE_W-1], r_prev_r};
  assign prod = PRW'($signed(diff) * $signed({1'b0, r_w_r}));

  always_ff @(posedge clk) begin
    if (accept) begin
      r_s_r        <= in_beat.sample_in;
      r_ch_r       <= in_beat.channel;
      r_fe_r       <= in_beat.frame_end;
      r_fwd_from_r <= !ch_ok || (from_cur == '0);
      r_fwd_to_r   <= !ch_ok || (to_cur == '0);
      r_to_addr_r  <= to_addr;
      r_w_r        <= weight;
    end
    if (r_valid_r && !r_phase_r) begin
      r_prev_r <= r_fwd_from_r ? r_s_r : ram_rdata;
    end
    if (r_leave) begin
      m_prod_r <= prod;
      m_prev_r <= r_prev_r;
      m_ch_r   <= r_ch_r;
      m_fe_r   <= r_fe_r;
    end
    if (m_valid_r && o_free) begin
      out_sample_r <= mix_sum[SAMPLE_W-1:0];
      out_ch_r     <= m_ch_r;
      out_fe_r     <= m_fe_r;
    end
  end

  // arithmetic shift gives floor of the division by the fade length
  assign prod_sh = m_prod_r >>> SH;
  assign mix_sum = {m_prev_r[SAMPLE_W-1], m_prev_r[SAMPLE_W-1], m_prev_r}
                 + prod_sh[SAMPLE_W+1:0];

  assign out_beat.valid         = out_valid_r;
  assign out_beat.sample_out    = out_sample_r;
  assign out_beat.out_channel   = out_ch_r;
  assign out_beat.out_frame_end = out_fe_r;

endmodule

>>> bench/tb_crossfading_multichannel_delay_line.sv
`timescale 1ns / 1ps
// self-checking bench for the crossfading multichannel delay line: predicts every beat

module tb_crossfading_multichannel_delay_line;
  import cfmdl_pkg::*;

  localparam int FADE_SHIFT   = $clog2(TRANSITION_LEN_DEF);
  localparam int QUIET_LIMIT  = 10000;
  localparam int DRAIN_CYCLES = 8;

  localparam sample_t S_MAX = 24'sh7FFFFF;
  localparam sample_t S_MIN = 24'sh800000;

  typedef struct {
    sample_t sample;
    logic    channel;
    logic    frame_end;
  } tap_beat_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   cfg_we;
  delay_t cfg_wdata;

  cfmdl_in_if  in_if ();
  cfmdl_out_if out_if ();

  crossfading_multichannel_delay_line DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_if),
    .out_beat (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor state
  sample_t     tap_store [CHANNELS_DEF][LINE_DEPTH_DEF];
  delay_t      line_max;
  int unsigned wr_pos;
  bit          delay_seen;
  int unsigned settled_d;
  int unsigned from_d;
  int unsigned to_d;
  int          frames_left;

  tap_beat_t delayed_q[$];
  int        fail_count = 0;
  bit        idle_on = 1'b1;
  int        out_stall = 0;
  int        quiet_cycles = 0;

  function automatic void clear_lines();
    foreach (tap_store[c, i]) tap_store[c][i] = '0;
    wr_pos      = 0;
    delay_seen  = 1'b0;
    settled_d   = 0;
    from_d      = 0;
    to_d        = 0;
    frames_left = 0;
  endfunction

  function automatic int unsigned line_tap(int unsigned wp, int unsigned d, int unsigned cap);
    return ((wp % cap) + cap - (d % cap)) % cap;
  endfunction

  function automatic sample_t mix_delayed_sample(sample_t s, logic ch, logic fe, delay_t req);
    int unsigned cap;
    int unsigned d;
    int unsigned wp;
    longint      prev;
    longint      tgt;
    longint      num;
    longint      mixed;
    cap = (line_max > LINE_DEPTH_DEF - 2) ? LINE_DEPTH_DEF : line_max + 2;
    if (ch == 1'b0) begin
      d = (req > cap - 1) ? cap - 1 : req;
      if (!delay_seen) begin
        delay_seen = 1'b1;
        settled_d  = d;
        from_d     = d;
        to_d       = d;
      end else if (d != to_d) begin
        // a new request always fades from the last settled delay
        from_d      = settled_d;
        to_d        = d;
        frames_left = TRANSITION_LEN_DEF;
      end
    end
    wp = wr_pos % cap;
    tap_store[ch][wp] = s;
    prev  = tap_store[ch][line_tap(wp, from_d, cap)];
    tgt   = tap_store[ch][line_tap(wp, to_d, cap)];
    num   = (tgt - prev) * longint'(TRANSITION_LEN_DEF - frames_left);
    mixed = prev + (num >>> FADE_SHIFT);
    if (fe) begin
      if (frames_left > 0) begin
        frames_left--;
        if (frames_left == 0) begin
          settled_d = to_d;
          from_d    = to_d;
        end
      end
      wr_pos = ((wr_pos % cap) + 1) % cap;
    end
    return sample_t'(mixed);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return S_MAX;
      1:       return S_MIN;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(sample_t s, logic ch, logic fe, delay_t req);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.sample_in     <= s;
    in_if.channel       <= ch;
    in_if.frame_end     <= fe;
    in_if.delay_request <= req;
    do @(posedge clk); while (!in_if.ready);
    delayed_q.push_back('{mix_delayed_sample(s, ch, fe, req), ch, fe});
  endtask

  task automatic settle_all();
    in_if.valid <= 1'b0;
    while (delayed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_max_delay(delay_t value);
    settle_all();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    line_max = value;
    clear_lines();
  endtask

  task automatic test_directed();
    int i;
    // channel 1 before any delay was seen returns what it just wrote
    send_sample(S_MAX, 1'b1, 1'b1, 10'd0);
    send_sample(S_MIN, 1'b1, 1'b1, 10'd1023);
    send_sample(24'sd100, 1'b0, 1'b0, 10'd3);
    send_sample(-24'sd100, 1'b1, 1'b1, 10'd0);
    for (i = 0; i < 4; i++) begin
      send_sample(i[0] ? S_MAX : S_MIN, 1'b0, 1'b0, 10'd3);
      send_sample(i[0] ? S_MIN : S_MAX, 1'b1, 1'b1, 10'd777);
    end
    // at the top of the line, starts a fade
    send_sample(S_MAX, 1'b0, 1'b0, 10'd1023);
    send_sample(S_MIN, 1'b1, 1'b1, 10'd0);
    send_sample(S_MIN, 1'b0, 1'b0, 10'd1023);
    send_sample(S_MAX, 1'b1, 1'b1, 10'd0);
    // change while fading
    send_sample(24'sd0, 1'b0, 1'b0, 10'd0);
    send_sample(24'sd1, 1'b1, 1'b1, 10'd1023);
    // frame with no channel 0, then single-beat frames
    send_sample(-24'sd1, 1'b1, 1'b1, 10'd0);
    send_sample(S_MAX, 1'b0, 1'b1, 10'd512);
    send_sample(S_MIN, 1'b0, 1'b1, 10'd0);
  endtask

  task automatic test_full_fade();
    int f;
    delay_t req;
    set_max_delay(10'd5);
    for (f = 0; f < 262; f++) begin
      req = (f < 2) ? 10'd2 : (f < 260) ? 10'd5 : 10'd0;
      // hold off mid-fade until every result is back
      if (f == 130) settle_all();
      send_sample(pick_sample(), 1'b0, 1'b0, req);
      send_sample(pick_sample(), 1'b1, 1'b1, delay_t'($urandom));
    end
  endtask

  task automatic test_random_mix(delay_t max_d, int n_items);
    int sent;
    delay_t req;
    set_max_delay(max_d);
    req  = delay_t'($urandom_range(0, 1023));
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 15) == 0)
        req = $urandom_range(0, 1) ? delay_t'($urandom_range(0, 7))
                                   : delay_t'($urandom_range(0, 1023));
      if ($urandom_range(0, 4) != 0) begin
        send_sample(pick_sample(), 1'b0, 1'b0, req);
        send_sample(pick_sample(), 1'b1, 1'b1, delay_t'($urandom));
        sent += 2;
      end else begin
        send_sample(pick_sample(), 1'($urandom), 1'($urandom), delay_t'($urandom));
        sent++;
      end
    end
  endtask

  // result checker and result-side stalls
  always @(posedge clk) begin
    tap_beat_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (delayed_q.size() == 0) begin
        $error("unexpected beat: sample_out %0d", out_if.sample_out);
        fail_count++;
      end else begin
        want = delayed_q.pop_front();
        if (out_if.sample_out !== want.sample) begin
          $error("sample_out: expected %0d, got %0d", want.sample, out_if.sample_out);
          fail_count++;
        end
        if (out_if.out_channel !== want.channel) begin
          $error("out_channel: expected %0d, got %0d", want.channel, out_if.out_channel);
          fail_count++;
        end
        if (out_if.out_frame_end !== want.frame_end) begin
          $error("out_frame_end: expected %0d, got %0d", want.frame_end,
                 out_if.out_frame_end);
          fail_count++;
        end
      end
    end
    if (out_stall > 0) begin
      out_stall--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall = $urandom_range(1, 6) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any beat moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** crossfading_multichannel_delay_line: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid         = 1'b0;
    in_if.sample_in     = '0;
    in_if.channel       = 1'b0;
    in_if.frame_end     = 1'b0;
    in_if.delay_request = '0;
    out_if.ready        = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    line_max = MAX_DELAY_RST;
    clear_lines();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_fade();
    test_random_mix(10'd0, 60);
    test_random_mix(10'd1023, 60);
    test_random_mix(10'd1022, 40);
    idle_on = 1'b0;
    test_random_mix(10'd3, 80);
    settle_all();

    if (fail_count == 0)
      $display("** crossfading_multichannel_delay_line: PASSED **");
    else
      $display("** crossfading_multichannel_delay_line: FAILED **");
    $finish;
  end

endmodule
